// ===== design/pack_entry_stream_decrypt_macros.svh =====
// Assertion macros for the pack entry stream decrypt block.
// Included by the top level; depends on nothing else.
`ifndef PACK_ENTRY_STREAM_DECRYPT_MACROS_SVH
`define PACK_ENTRY_STREAM_DECRYPT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PESD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PESD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pesd_pkg.sv =====
// Shared types and constants of the pack entry stream decrypt block.
// Used by every module of the block; depends on nothing.
package pesd_pkg;

    localparam int POS_W     = 48;
    localparam int KEY_W     = 64;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TAP_W     = 40;
    localparam int MUL_LO_W  = 32;

    localparam logic [KEY_W-1:0] MIX_CONST = 64'h351c_d819_923a_cae7;

    localparam logic [CFG_IDX_W-1:0] CFG_PACK_KEY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LENGTH = 2'd2;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [1:0] {
        MODE_SEEK  = 2'd0,
        MODE_TELL  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ORG_START   = 2'd0,
        ORG_CURRENT = 2'd1,
        ORG_END     = 2'd2,
        ORG_INVALID = 2'd3
    } origin_t;

    typedef struct packed {
        mode_t                    mode;
        origin_t                  seek_origin;
        logic signed [POS_W-1:0]  seek_delta;
        logic [POS_W-1:0]         read_length;
        logic [BYTE_W-1:0]        raw_byte;
    } item_t;

    typedef struct packed {
        logic              status;
        logic [POS_W-1:0]  position;
    } pos_res_t;

endpackage

// ===== design/pesd_in_stage.sv =====
// Input register of the pack entry stream decrypt block.
// Depends on pesd_pkg for the item type.
module pesd_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pesd_pkg::item_t s_item,
    input  logic            out_free,
    output logic            item_valid,
    output pesd_pkg::item_t item
);
    import pesd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign s_ready = !valid_reg || out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_free) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/pesd_pos_unit.sv =====
// Configuration registers and position tracking of the pack entry stream decrypt block.
// Depends on pesd_pkg; the position is held relative to the entry start.
module pesd_pos_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pesd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pesd_pkg::KEY_W-1:0]          cfg_data,
    input  logic                                step,
    input  pesd_pkg::item_t                     item,
    output logic [pesd_pkg::TAP_W-1:0]          key_tap,
    output logic [pesd_pkg::POS_W-1:0]          cur_rel,
    output pesd_pkg::pos_res_t                  res
);
    import pesd_pkg::*;

    localparam int SUM_W = POS_W + 2;

    logic [KEY_W-1:0] key_reg;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] length_reg;
    logic [POS_W-1:0] rel_reg;
    logic [POS_W-1:0] rel_next;

    logic [POS_W-1:0] limit;
    logic [SUM_W-1:0] delta_ext;
    logic [SUM_W-1:0] rel_base;
    logic [SUM_W-1:0] seek_sum;
    logic             seek_bad;
    logic [POS_W:0]   run_sum;
    logic             check_bad;
    logic             at_top;
    logic             status;
    logic [POS_W-1:0] rel_after;
    logic             start_write;

    // The absolute position never passes 2^48-1, so the relative one never passes ~start.
    assign limit     = ~start_reg;
    assign delta_ext = {{2{item.seek_delta[POS_W-1]}}, item.seek_delta};

    always_comb begin
        case (item.seek_origin)
            ORG_START:   rel_base = '0;
            ORG_CURRENT: rel_base = {2'b00, rel_reg};
            ORG_END:     rel_base = {2'b00, length_reg};
            default:     rel_base = '0;
        endcase
    end

    assign seek_sum  = rel_base + delta_ext;
    assign seek_bad  = (item.seek_origin == ORG_INVALID) || seek_sum[SUM_W-1]
                       || (seek_sum > {2'b00, limit});
    assign run_sum   = {1'b0, rel_reg} + {1'b0, item.read_length};
    assign check_bad = (run_sum > {1'b0, length_reg}) || (run_sum > {1'b0, limit});
    assign at_top    = (rel_reg == limit);

    always_comb begin
        status    = STATUS_OK;
        rel_after = rel_reg;
        unique case (item.mode)
            MODE_SEEK: begin
                if (seek_bad) begin
                    status = STATUS_REJECT;
                end else begin
                    rel_after = seek_sum[POS_W-1:0];
                end
            end
            MODE_TELL: begin
                status = STATUS_OK;
            end
            MODE_CHECK: begin
                if (check_bad) begin
                    status = STATUS_REJECT;
                end
            end
            MODE_READ: begin
                if (at_top) begin
                    status = STATUS_REJECT;
                end else begin
                    rel_after = rel_reg + POS_W'(1);
                end
            end
            default: begin
                status = STATUS_REJECT;
            end
        endcase
    end

    assign start_write = cfg_we && (cfg_index == CFG_ENTRY_START);

    always_comb begin
        if (start_write) begin
            rel_next = '0;
        end else if (step) begin
            rel_next = rel_after;
        end else begin
            rel_next = rel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg    <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            rel_reg    <= '0;
        end else begin
            rel_reg <= rel_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PACK_KEY:     key_reg    <= cfg_data;
                    CFG_ENTRY_START:  start_reg  <= cfg_data[POS_W-1:0];
                    CFG_ENTRY_LENGTH: length_reg <= cfg_data[POS_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    assign key_tap = rel_reg[TAP_W-1:0] ^ key_reg[TAP_W-1:0];
    assign cur_rel = rel_reg;
    assign res     = '{status: status, position: rel_after};

endmodule

// ===== design/pesd_key_mul.sv =====
// Key byte generator: bits 39..32 of the keyed position times the mixing constant.
// Depends on pesd_pkg; partial products are registered and summed in the result stage.
module pesd_key_mul (
    input  logic                              aclk,
    input  logic                              load,
    input  logic [pesd_pkg::TAP_W-1:0]        key_tap,
    output logic [pesd_pkg::BYTE_W-1:0]       key_byte
);
    import pesd_pkg::*;

    localparam logic [MUL_LO_W-1:0] MIX_LO      = MIX_CONST[MUL_LO_W-1:0];
    localparam logic [BYTE_W-1:0]   MIX_LO_BYTE = MIX_CONST[BYTE_W-1:0];
    localparam logic [BYTE_W-1:0]   MIX_HI_BYTE = MIX_CONST[TAP_W-1:MUL_LO_W];

    logic [2*MUL_LO_W-1:0] lo_prod;
    logic [2*BYTE_W-1:0]   hi_a;
    logic [2*BYTE_W-1:0]   hi_b;
    logic [BYTE_W-1:0]     lo_byte_next;
    logic [BYTE_W-1:0]     cross_next;
    logic [BYTE_W-1:0]     lo_byte_reg;
    logic [BYTE_W-1:0]     cross_reg;

    // Only the low 40 bits of both factors reach bits 39..32 of the product.
    assign lo_prod = {{MUL_LO_W{1'b0}}, key_tap[MUL_LO_W-1:0]} * {{MUL_LO_W{1'b0}}, MIX_LO};
    assign hi_a    = {{BYTE_W{1'b0}}, key_tap[TAP_W-1:MUL_LO_W]} * {{BYTE_W{1'b0}}, MIX_LO_BYTE};
    assign hi_b    = {{BYTE_W{1'b0}}, key_tap[BYTE_W-1:0]} * {{BYTE_W{1'b0}}, MIX_HI_BYTE};

    assign lo_byte_next = lo_prod[TAP_W-1:MUL_LO_W];
    assign cross_next   = hi_a[BYTE_W-1:0] + hi_b[BYTE_W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            lo_byte_reg <= lo_byte_next;
            cross_reg   <= cross_next;
        end
    end

    assign key_byte = lo_byte_reg + cross_reg;

endmodule

// ===== design/pesd_out_stage.sv =====
// Result register of the pack entry stream decrypt block.
// Depends on pesd_pkg; applies the key byte to the registered raw byte.
module pesd_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  pesd_pkg::pos_res_t                res,
    input  logic                              is_read,
    input  logic [pesd_pkg::BYTE_W-1:0]       raw_byte,
    input  logic [pesd_pkg::BYTE_W-1:0]       key_byte,
    input  logic                              m_ready,
    output logic                              out_free,
    output logic                              m_valid,
    output logic                              m_status,
    output logic [pesd_pkg::BYTE_W-1:0]       m_plain_byte,
    output logic [pesd_pkg::POS_W-1:0]        m_position
);
    import pesd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    pos_res_t          res_reg;
    logic              is_read_reg;
    logic [BYTE_W-1:0] raw_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        if (step) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg     <= res;
            is_read_reg <= is_read;
            raw_reg     <= raw_byte;
        end
    end

    assign m_valid      = valid_reg;
    assign m_status     = res_reg.status;
    assign m_position   = res_reg.position;
    assign m_plain_byte = is_read_reg ? (raw_reg ^ key_byte) : '0;

endmodule

// ===== design/pack_entry_stream_decrypt.sv =====
// Decrypting reader for one entry of a resource pack: seek, tell, read check and read byte.
// Top level; depends on pesd_pkg, pesd_in_stage, pesd_pos_unit, pesd_key_mul and
// pesd_out_stage.
//
// The block takes one item per clock cycle while the output is not stalled and returns
// each result through an input register and a result register. The rate is set by the
// position register, which is updated at most once per cycle by a single add and compare;
// the key multiplication is split into a 32 by 32 bit product and two small cross terms,
// summed after the result register. Configuration writes are taken at any time with ready
// held high and must only be issued while no item is in flight. There is no clearing pass.
`include "pack_entry_stream_decrypt_macros.svh"

module pack_entry_stream_decrypt (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pesd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pesd_pkg::KEY_W-1:0]            cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  pesd_pkg::mode_t                       s_mode,
    input  pesd_pkg::origin_t                     s_seek_origin,
    input  logic signed [pesd_pkg::POS_W-1:0]     s_seek_delta,
    input  logic [pesd_pkg::POS_W-1:0]            s_read_length,
    input  logic [pesd_pkg::BYTE_W-1:0]           s_raw_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_status,
    output logic [pesd_pkg::BYTE_W-1:0]           m_plain_byte,
    output logic [pesd_pkg::POS_W-1:0]            m_position
);
    import pesd_pkg::*;

    item_t             s_item;
    item_t             in_item;
    logic              in_valid;
    logic              out_free;
    logic              step;
    logic [TAP_W-1:0]  key_tap;
    logic [POS_W-1:0]  cur_rel;
    pos_res_t          pos_res;
    logic [BYTE_W-1:0] key_byte;

    assign cfg_ready = 1'b1;

    assign s_item = '{mode:        s_mode,
                      seek_origin: s_seek_origin,
                      seek_delta:  s_seek_delta,
                      read_length: s_read_length,
                      raw_byte:    s_raw_byte};

    assign step = in_valid && out_free;

    pesd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .out_free   (out_free),
        .item_valid (in_valid),
        .item       (in_item)
    );

    pesd_pos_unit u_pos_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (in_item),
        .key_tap   (key_tap),
        .cur_rel   (cur_rel),
        .res       (pos_res)
    );

    pesd_key_mul u_key_mul (
        .aclk     (aclk),
        .load     (step),
        .key_tap  (key_tap),
        .key_byte (key_byte)
    );

    pesd_out_stage u_out_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .res          (pos_res),
        .is_read      (in_item.mode == MODE_READ),
        .raw_byte     (in_item.raw_byte),
        .key_byte     (key_byte),
        .m_ready      (m_ready),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_status     (m_status),
        .m_plain_byte (m_plain_byte),
        .m_position   (m_position)
    );

    `PESD_ASSERT_SAME(a_full_stall, aclk, aresetn,
        in_valid && m_valid && !m_ready, !s_ready,
        "input taken while both stages are full")
    `PESD_ASSERT_SAME(a_tell_holds, aclk, aresetn,
        step && in_item.mode == MODE_TELL,
        pos_res.position == cur_rel && pos_res.status == STATUS_OK,
        "tell changed the position")
    `PESD_ASSERT_NEXT(a_read_advance, aclk, aresetn,
        step && in_item.mode == MODE_READ && pos_res.status == STATUS_OK,
        m_position == $past(cur_rel) + POS_W'(1),
        "read byte did not advance by one")

endmodule

// ===== bench/pesd_decrypt_checker.sv =====
`timescale 1ns / 1ps
// Checker for the pack entry stream decrypt block: it watches the configuration, input and
// result channels, predicts every result and compares it field by field.
// Depends on pesd_pkg.
module pesd_decrypt_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [pesd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pesd_pkg::KEY_W-1:0]           cfg_data,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  pesd_pkg::mode_t                      s_mode,
    input  pesd_pkg::origin_t                    s_seek_origin,
    input  logic signed [pesd_pkg::POS_W-1:0]    s_seek_delta,
    input  logic [pesd_pkg::POS_W-1:0]           s_read_length,
    input  logic [pesd_pkg::BYTE_W-1:0]          s_raw_byte,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic                                 m_status,
    input  logic [pesd_pkg::BYTE_W-1:0]          m_plain_byte,
    input  logic [pesd_pkg::POS_W-1:0]           m_position,
    output int                                   fail_count,
    output int                                   replies_owed
);
    import pesd_pkg::*;

    localparam logic [63:0] POS_TOP = 64'h0000_ffff_ffff_ffff;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] plain_byte;
        logic [POS_W-1:0]  position;
    } entry_reply_t;

    logic [KEY_W-1:0] pack_key;
    logic [POS_W-1:0] entry_start;
    logic [POS_W-1:0] entry_length;
    logic [POS_W-1:0] read_offset;
    entry_reply_t     reply_q[$];
    entry_reply_t     want;

    initial begin
        fail_count   = 0;
        replies_owed = 0;
        pack_key     = '0;
        entry_start  = '0;
        entry_length = '0;
        read_offset  = '0;
    end

    function automatic entry_reply_t step_entry_reader(
        input mode_t                   mode,
        input origin_t                 origin,
        input logic signed [POS_W-1:0] delta,
        input logic [POS_W-1:0]        run_length,
        input logic [BYTE_W-1:0]       raw
    );
        logic signed [63:0] base;
        logic signed [63:0] target;
        logic [63:0]        run_end;
        logic [63:0]        entry_end;
        logic [63:0]        mixed;
        logic [POS_W-1:0]   rel;
        entry_reply_t       rep;
        rep.status     = STATUS_OK;
        rep.plain_byte = '0;
        base           = '0;
        entry_end      = {16'h0, entry_start} + {16'h0, entry_length};
        case (mode)
            MODE_SEEK: begin
                case (origin)
                    ORG_START:   base = $signed({16'h0, entry_start});
                    ORG_CURRENT: base = $signed({16'h0, read_offset});
                    ORG_END:     base = $signed(entry_end);
                    default:     rep.status = STATUS_REJECT;
                endcase
                if (rep.status == STATUS_OK) begin
                    target = base + $signed({{16{delta[POS_W-1]}}, delta});
                    if (target < $signed({16'h0, entry_start}) || target > $signed(POS_TOP)) begin
                        rep.status = STATUS_REJECT;
                    end else begin
                        read_offset = target[POS_W-1:0];
                    end
                end
            end
            MODE_TELL: begin
                rep.status = STATUS_OK;
            end
            MODE_CHECK: begin
                run_end = {16'h0, read_offset} + {16'h0, run_length};
                if (run_end > entry_end || run_end > POS_TOP) begin
                    rep.status = STATUS_REJECT;
                end
            end
            default: begin
                rel   = read_offset - entry_start;
                mixed = ({16'h0, rel} ^ pack_key) * MIX_CONST;
                rep.plain_byte = raw ^ mixed[39:32];
                if ({16'h0, read_offset} == POS_TOP) begin
                    rep.status = STATUS_REJECT;
                end else begin
                    read_offset = read_offset + 1'b1;
                end
            end
        endcase
        rep.position = read_offset - entry_start;
        return rep;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pack_key     = '0;
            entry_start  = '0;
            entry_length = '0;
            read_offset  = '0;
            reply_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PACK_KEY: pack_key = cfg_data;
                    CFG_ENTRY_START: begin
                        entry_start = cfg_data[POS_W-1:0];
                        read_offset = cfg_data[POS_W-1:0];
                    end
                    CFG_ENTRY_LENGTH: entry_length = cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                reply_q.push_back(step_entry_reader(s_mode, s_seek_origin, s_seek_delta,
                                                    s_read_length, s_raw_byte));
            end
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_plain_byte !== want.plain_byte) begin
                        $error("plain_byte: expected %02h, actual %02h",
                               want.plain_byte, m_plain_byte);
                        fail_count++;
                    end
                    if (m_position !== want.position) begin
                        $error("position: expected %012h, actual %012h",
                               want.position, m_position);
                        fail_count++;
                    end
                end
            end
        end
        replies_owed = reply_q.size();
    end

endmodule

// ===== bench/tb_pack_entry_stream_decrypt.sv =====
`timescale 1ns / 1ps
// Top of the pack entry stream decrypt testbench: clock, reset, configuration phases and
// directed and random items with random gaps. Depends on pesd_pkg, pesd_decrypt_checker
// and the block itself.
module tb_pack_entry_stream_decrypt;
    import pesd_pkg::*;

    localparam logic [POS_W-1:0] POS_TOP    = {POS_W{1'b1}};
    localparam int               PHASE_LEN  = 185;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index     = CFG_PACK_KEY;
    logic [KEY_W-1:0]         cfg_data      = '0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    mode_t                    s_mode        = MODE_TELL;
    origin_t                  s_seek_origin = ORG_START;
    logic signed [POS_W-1:0]  s_seek_delta  = '0;
    logic [POS_W-1:0]         s_read_length = '0;
    logic [BYTE_W-1:0]        s_raw_byte    = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic                     m_status;
    logic [BYTE_W-1:0]        m_plain_byte;
    logic [POS_W-1:0]         m_position;

    int                       fail_count;
    int                       replies_owed;
    logic                     steady        = 1'b0;
    logic [POS_W-1:0]         length_now    = '0;

    pack_entry_stream_decrypt dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_seek_origin (s_seek_origin),
        .s_seek_delta  (s_seek_delta),
        .s_read_length (s_read_length),
        .s_raw_byte    (s_raw_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_plain_byte  (m_plain_byte),
        .m_position    (m_position)
    );

    pesd_decrypt_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_seek_origin (s_seek_origin),
        .s_seek_delta  (s_seek_delta),
        .s_read_length (s_read_length),
        .s_raw_byte    (s_raw_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_plain_byte  (m_plain_byte),
        .m_position    (m_position),
        .fail_count    (fail_count),
        .replies_owed  (replies_owed)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("pack_entry_stream_decrypt: mismatch");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 12);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t make_item(
        input mode_t                   mode,
        input origin_t                 origin,
        input logic signed [POS_W-1:0] delta,
        input logic [POS_W-1:0]        run_length,
        input logic [BYTE_W-1:0]       raw
    );
        item_t it;
        it.mode        = mode;
        it.seek_origin = origin;
        it.seek_delta  = delta;
        it.read_length = run_length;
        it.raw_byte    = raw;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t            it;
        int               roll;
        int               span;
        int               offs;
        logic [63:0]      bits;
        bits = rand64();
        it   = make_item(mode_t'($urandom_range(3)), origin_t'($urandom_range(3)),
                         bits[POS_W-1:0], POS_W'(rand64()), BYTE_W'($urandom));
        span = (length_now > 48'd4000) ? 4000 : int'(length_now);
        roll = $urandom_range(99);
        if (roll < 8) begin
            return it;
        end else if (roll < 55) begin
            it.mode = MODE_READ;
        end else if (roll < 72) begin
            it.mode        = MODE_SEEK;
            it.seek_origin = ($urandom_range(9) == 0) ? ORG_INVALID
                                                      : origin_t'($urandom_range(2));
            if ($urandom_range(3) != 0) begin
                offs = int'($urandom_range(2 * span + 32)) - (span + 16);
                it.seek_delta = {{16{offs[31]}}, offs};
            end
        end else if (roll < 88) begin
            it.mode = MODE_CHECK;
            if ($urandom_range(3) != 0) begin
                it.read_length = POS_W'($urandom_range(span + 8));
            end
        end else begin
            it.mode = MODE_TELL;
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (!steady) begin
            while ($urandom_range(99) < 12) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_mode        <= it.mode;
        s_seek_origin <= it.seek_origin;
        s_seek_delta  <= it.seek_delta;
        s_read_length <= it.read_length;
        s_raw_byte    <= it.raw_byte;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (replies_owed != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [KEY_W-1:0] key, input logic [POS_W-1:0] start,
                             input logic [POS_W-1:0] length);
        settle();
        write_reg(CFG_PACK_KEY, key);
        write_reg(CFG_ENTRY_START, {16'h0, start});
        write_reg(CFG_ENTRY_LENGTH, {16'h0, length});
        length_now = length;
    endtask

    initial begin
        logic [POS_W-1:0] start_sel;
        logic [POS_W-1:0] length_sel;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty entry at offset zero with an all-ones key.
        configure({KEY_W{1'b1}}, '0, '0);
        send_item(make_item(MODE_TELL, ORG_START, '0, '0, 8'h00));
        send_item(make_item(MODE_CHECK, ORG_START, '0, '0, 8'h00));
        send_item(make_item(MODE_CHECK, ORG_START, '0, 48'd1, 8'h00));
        send_item(make_item(MODE_SEEK, ORG_START, '1, '0, 8'h00));
        send_item(make_item(MODE_SEEK, ORG_END, '0, '0, 8'h00));
        send_item(make_item(MODE_SEEK, ORG_INVALID, 48'sd3, '0, 8'h00));
        send_item(make_item(MODE_SEEK, ORG_CURRENT, 48'sh7fff_ffff_ffff, '0, 8'h00));
        send_item(make_item(MODE_READ, ORG_START, '0, '0, 8'hff));
        send_item(make_item(MODE_SEEK, ORG_CURRENT, 48'sh8000_0000_0000, '0, 8'h00));
        send_item(make_item(MODE_READ, ORG_INVALID, '1, POS_TOP, 8'h00));

        // Entry at the very top of the position range, so the position saturates.
        configure('0, POS_TOP - 48'd4, POS_TOP);
        send_item(make_item(MODE_SEEK, ORG_END, '0, '0, 8'h00));
        send_item(make_item(MODE_SEEK, ORG_END, 48'sh8000_0000_0000, '0, 8'h00));
        send_item(make_item(MODE_SEEK, ORG_START, 48'sd4, '0, 8'h00));
        send_item(make_item(MODE_READ, ORG_START, '0, '0, 8'h5a));
        send_item(make_item(MODE_CHECK, ORG_START, '0, '0, 8'h00));
        send_item(make_item(MODE_CHECK, ORG_START, '0, 48'd1, 8'h00));
        send_item(make_item(MODE_CHECK, ORG_START, '0, POS_TOP, 8'h00));
        send_item(make_item(MODE_SEEK, ORG_START, 48'sd5, '0, 8'h00));
        send_item(make_item(MODE_SEEK, ORG_CURRENT, -48'sd4, '0, 8'h00));
        send_item(make_item(MODE_READ, ORG_START, '0, '0, BYTE_W'($urandom)));
        send_item(make_item(MODE_TELL, ORG_START, '0, '0, 8'h00));
        send_item(make_item(MODE_CHECK, ORG_START, '0, 48'd4, 8'h00));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    start_sel  = POS_W'($urandom_range(1000));
                    length_sel = POS_W'(1 + $urandom_range(299));
                end
                1: begin
                    start_sel  = POS_W'(rand64());
                    length_sel = POS_W'(rand64());
                end
                2: begin
                    start_sel  = '0;
                    length_sel = POS_TOP;
                end
                default: begin
                    start_sel  = POS_TOP - 48'd300;
                    length_sel = 48'd200;
                end
            endcase
            configure(rand64(), start_sel, length_sel);
            for (int n = 0; n < PHASE_LEN; n++) begin
                steady = (phase == 0) && (n < 120);
                if (n == PHASE_LEN / 2) begin
                    settle();
                end
                send_item(random_item());
            end
        end
        steady = 1'b0;

        settle();
        if (fail_count == 0) begin
            $display("pack_entry_stream_decrypt: match");
        end else begin
            $display("pack_entry_stream_decrypt: mismatch");
        end
        $finish;
    end

endmodule
